// ----- design/gfwe_pkg.sv -----
// Shared constants, types and table function for the glottal flow waveform evaluator.
`default_nettype none

package gfwe_pkg;

  localparam int unsigned PHASE_FRAC_BITS_DEF = 16;
  localparam int unsigned EXP_SEGMENTS_DEF    = 64;

  localparam longint LN2_Q30   = 744261118;
  localparam longint ONE_Q30   = 1073741824;
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

  // Config register indexes
  typedef enum logic [2:0] {
    REG_GAIN_K      = 3'd0,
    REG_OPEN_END    = 3'd1,
    REG_PEAK_TIME   = 3'd2,
    REG_SHAPE_TIME  = 3'd3,
    REG_INV_RET     = 3'd4,
    REG_RET_SCALE   = 3'd5,
    REG_EXP_FLOOR   = 3'd6,
    REG_FLOW_CLOSE  = 3'd7
  } cfg_reg_e;

  // Reset values of the time registers
  localparam logic [16:0] OPEN_END_RST   = 17'd39322;
  localparam logic [16:0] PEAK_TIME_RST  = 17'd27525;
  localparam logic [16:0] SHAPE_TIME_RST = 17'd45875;

  // Load enables for the two exp stages
  typedef struct packed {
    logic lookup;
    logic interp;
  } exp_en_t;

  // ceil(2^34/n) for n = 1..16; exact floor division of series terms below 2^30
  localparam int unsigned RECIP_SHIFT = 34;
  localparam logic [34:0] RECIP_BASE  = 35'd1 << RECIP_SHIFT;
  localparam logic [15:0][34:0] SERIES_RECIP = {
    (RECIP_BASE + 35'd15) / 35'd16, (RECIP_BASE + 35'd14) / 35'd15,
    (RECIP_BASE + 35'd13) / 35'd14, (RECIP_BASE + 35'd12) / 35'd13,
    (RECIP_BASE + 35'd11) / 35'd12, (RECIP_BASE + 35'd10) / 35'd11,
    (RECIP_BASE + 35'd9) / 35'd10,  (RECIP_BASE + 35'd8) / 35'd9,
    (RECIP_BASE + 35'd7) / 35'd8,   (RECIP_BASE + 35'd6) / 35'd7,
    (RECIP_BASE + 35'd5) / 35'd6,   (RECIP_BASE + 35'd4) / 35'd5,
    (RECIP_BASE + 35'd3) / 35'd4,   (RECIP_BASE + 35'd2) / 35'd3,
    (RECIP_BASE + 35'd1) / 35'd2,   RECIP_BASE
  };

  // Node value: series of exp(-z) through the z^16 term, z in Q0.30, result Q0.30
  function automatic logic [30:0] exp_node(input longint z);
    longint      part;
    longint      term;
    longint      sum;
    logic [98:0] scaled;
    term = ONE_Q30;
    sum  = ONE_Q30;
    for (int n = 1; n <= 16; n++) begin
      part   = (term * z) >>> 30;
      scaled = 99'(part) * SERIES_RECIP[n-1];
      term   = longint'(scaled[RECIP_SHIFT +: 64]);
      if (n[0]) sum = sum - term;
      else sum = sum + term;
    end
    if (sum < 0) sum = 0;
    if (sum > ONE_Q30) sum = ONE_Q30;
    return sum[30:0];
  endfunction

endpackage

`default_nettype wire

// ----- design/gfwe_exp.sv -----
// Two-stage exp(-x) core: node lookup, then linear interpolation.
`default_nettype none

module gfwe_exp #(
  parameter int unsigned PHASE_FRAC_BITS = gfwe_pkg::PHASE_FRAC_BITS_DEF,
  parameter int unsigned EXP_SEGMENTS    = gfwe_pkg::EXP_SEGMENTS_DEF
) (
  input  wire logic                       clk_i,
  input  wire gfwe_pkg::exp_en_t          en_i,
  input  wire logic [PHASE_FRAC_BITS+6:0] y_i,   // x*log2(e), Q.F
  output logic [6:0]                      n_o,   // integer part of the power
  output logic [30:0]                     v_o    // 2^-frac, Q0.30
);

  localparam int unsigned F   = PHASE_FRAC_BITS;
  localparam int unsigned KW  = $clog2(EXP_SEGMENTS + 1);

  logic [30:0]    node_tab [EXP_SEGMENTS+1];
  logic [F+KW-1:0] pos;
  logic [KW-1:0]   k;
  logic [30:0]     lo_q, hi_q, v_q;
  logic [F-1:0]    w_q;
  logic [6:0]      n1_q, n2_q;
  logic [30:0]     diff;
  logic [F+30:0]   dprod;

  for (genvar g = 0; g <= EXP_SEGMENTS; g++) begin : g_node
    localparam longint NodeZ = (longint'(g) * gfwe_pkg::LN2_Q30) / EXP_SEGMENTS;
    localparam logic [30:0] NodeVal = gfwe_pkg::exp_node(NodeZ);
    assign node_tab[g] = NodeVal;
  end

  assign pos = y_i[F-1:0] * KW'(EXP_SEGMENTS);
  assign k   = pos[F +: KW];

  always_ff @(posedge clk_i) begin
    if (en_i.lookup) begin
      lo_q <= node_tab[k];
      hi_q <= node_tab[KW'(k + 1'b1)];
      w_q  <= pos[F-1:0];
      n1_q <= y_i[F +: 7];
    end
  end

  assign diff  = lo_q - hi_q;
  assign dprod = diff * w_q;

  always_ff @(posedge clk_i) begin
    if (en_i.interp) begin
      v_q  <= lo_q - dprod[F +: 31];
      n2_q <= n1_q;
    end
  end

  assign v_o = v_q;
  assign n_o = n2_q;

endmodule

`default_nettype wire

// ----- design/glottal_flow_waveform_evaluator.sv -----
// Top level: R++ glottal flow / flow-derivative evaluator, seven-stage pipeline.
//
// Usage:
//  - Input stream (s_axis_*): tdata carries the phase t (unsigned Q1.F, 1<<F is one
//    period), tuser carries the operation: 0 asks for dg(t), 1 for g(t).
//  - Output stream (m_axis_*): tdata carries the saturated signed Q16.16 sample,
//    tuser is set when t lay beyond the open-phase end Te.
//  - Config port (cfg_*): index 0..7 selects gain_k, open_end, peak_time,
//    shape_time, inv_return_time, return_area_scale, exp_floor, flow_at_closure.
//    cfg_ready_o is always high; write only while no item is in flight.
//  - Throughput: one item per cycle while the output stream is not stalled. Each
//    stage holds at most one multiplier level; the longest branch (return-phase
//    exp lookup and interpolation) sets the depth.
//  - Every stage carries its own valid bit and loads when it is empty or the stage
//    after it moves, so bubbles close up and a stalled output keeps its item
//    while earlier stages still fill.
//  - Reset empties the pipeline and loads the register defaults; the block
//    keeps no state between items.
`default_nettype none

module glottal_flow_waveform_evaluator #(
  parameter int unsigned PHASE_FRAC_BITS = gfwe_pkg::PHASE_FRAC_BITS_DEF,
  parameter int unsigned EXP_SEGMENTS    = gfwe_pkg::EXP_SEGMENTS_DEF,
  localparam int unsigned InDataW = ((PHASE_FRAC_BITS + 1 + 7) / 8) * 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  wire logic [InDataW-1:0] s_axis_tdata_i,   // phase, zero padded
  input  wire logic               s_axis_tuser_i,   // operation
  output logic                    m_axis_tvalid_o,
  input  wire logic               m_axis_tready_i,
  output logic [31:0]             m_axis_tdata_o,   // sample_value
  output logic                    m_axis_tuser_o,   // in_return_phase
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [2:0]         cfg_addr_i,
  input  wire logic [31:0]        cfg_data_i
);

  localparam int unsigned F    = PHASE_FRAC_BITS;
  localparam int unsigned TW   = F + 1;          // time format
  localparam int unsigned AW   = F + 3;          // t*(Tp-t)
  localparam int unsigned BW   = F + 4;          // a*(Tx-t)
  localparam int unsigned SW   = F + 5;          // t2 - 4ts/3 + 2pq
  localparam int unsigned XW   = F + 17;         // x = (t-Te)/Ta
  localparam int unsigned YW   = F + 7;          // x*log2(e)
  localparam int unsigned XFW  = F + 18;         // x*E
  localparam int unsigned TMW  = F + 19;         // 1 - e - x*E
  localparam int unsigned PVW  = 37;             // polynomial results
  localparam int unsigned PPW  = 34;             // R*(e-E)
  localparam int unsigned VW   = 52;             // return-phase results
  localparam int unsigned NST  = 7;
  localparam int unsigned K3   = F + 7;          // reciprocal of 3
  localparam longint unsigned M3 = ((64'd1 << K3) + 2) / 3;

  localparam logic [TW-1:0] OneT = {1'b1, {F{1'b0}}};
  localparam logic [XW-1:0] XLim = XW'(64) << F;
  localparam logic [K3-1:0] M3V  = K3'(M3);

  // ---------------- configuration ----------------
  logic signed [31:0] gain_q, rscale_q, gte_q;
  logic [TW-1:0]      te_q, tp_q, tx_q, fl_q;
  logic [31:0]        irt_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= '0;
      te_q     <= TW'(gfwe_pkg::OPEN_END_RST);
      tp_q     <= TW'(gfwe_pkg::PEAK_TIME_RST);
      tx_q     <= TW'(gfwe_pkg::SHAPE_TIME_RST);
      irt_q    <= '0;
      rscale_q <= '0;
      fl_q     <= '0;
      gte_q    <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (gfwe_pkg::cfg_reg_e'(cfg_addr_i))
        gfwe_pkg::REG_GAIN_K:     gain_q   <= $signed(cfg_data_i);
        gfwe_pkg::REG_OPEN_END:   te_q     <= cfg_data_i[TW-1:0];
        gfwe_pkg::REG_PEAK_TIME:  tp_q     <= cfg_data_i[TW-1:0];
        gfwe_pkg::REG_SHAPE_TIME: tx_q     <= cfg_data_i[TW-1:0];
        gfwe_pkg::REG_INV_RET:    irt_q    <= cfg_data_i;
        gfwe_pkg::REG_RET_SCALE:  rscale_q <= $signed(cfg_data_i);
        gfwe_pkg::REG_EXP_FLOOR:  fl_q     <= cfg_data_i[TW-1:0];
        gfwe_pkg::REG_FLOW_CLOSE: gte_q    <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  logic [NST-1:0] v_q, en;

  always_comb begin
    en[NST-1] = !v_q[NST-1] || m_axis_tready_i;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !v_q[i] || en[i+1];
    end
  end

  assign s_axis_tready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= s_axis_tvalid_i;
      for (int i = 1; i < NST; i++) begin
        if (en[i]) v_q[i] <= v_q[i-1];
      end
    end
  end

  // ---------------- stage 0: clamp, first products ----------------
  logic [TW-1:0]          phase, t_c, dt;
  logic signed [AW-1:0]   d_tp;
  logic signed [2*AW-1:0] a_prod;
  logic [2*TW-1:0]        t2_prod, pq_prod;
  logic [2*F+2:0]         ts_prod;
  logic [TW+31:0]         x_prod;

  assign phase   = s_axis_tdata_i[TW-1:0];
  assign t_c     = (phase > OneT) ? OneT : phase;
  assign d_tp    = $signed({2'b00, tp_q}) - $signed({2'b00, t_c});
  assign a_prod  = $signed({2'b00, t_c}) * d_tp;
  assign t2_prod = t_c * t_c;
  assign ts_prod = t_c * ({1'b0, tp_q} + {1'b0, tx_q});
  assign pq_prod = tp_q * tx_q;
  assign dt      = t_c - te_q;
  assign x_prod  = dt * irt_q;

  logic               op1_q, ret1_q, abr1_q;
  logic [TW-1:0]      t1_q, t2a1_q;
  logic signed [AW-1:0] a1_q;
  logic [F+2:0]       ts1_q;
  logic [F+1:0]       pq1_q;
  logic [XW-1:0]      x1_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      op1_q  <= s_axis_tuser_i;
      ret1_q <= t_c > te_q;
      abr1_q <= irt_q == '0;
      t1_q   <= t_c;
      a1_q   <= AW'(a_prod >>> F);
      t2a1_q <= t2_prod[F +: TW];
      ts1_q  <= ts_prod[F +: F+3];
      pq1_q  <= pq_prod[F +: F+2];
      x1_q   <= x_prod[16 +: XW];
    end
  end

  // ---------------- stage 1 ----------------
  logic signed [AW-1:0]   d_tx;
  logic signed [2*AW-1:0] b_prod;
  logic [F+K3+4:0]        ft_prod;
  logic [F+36:0]          y_prod;
  logic [XW+TW-1:0]       xf_prod;

  assign d_tx    = $signed({2'b00, tx_q}) - $signed({2'b00, t1_q});
  assign b_prod  = a1_q * d_tx;
  assign ft_prod = {ts1_q, 2'b00} * M3V;
  assign y_prod  = x1_q[F+5:0] * gfwe_pkg::LOG2E_Q30;
  assign xf_prod = x1_q * fl_q;

  logic               op2_q, ret2_q, abr2_q, large2_q;
  logic signed [BW-1:0] b2_q;
  logic [F+2:0]       ft2_q;
  logic [TW-1:0]      t2a2_q;
  logic [F+1:0]       pq2_q;
  logic [YW-1:0]      y2_q;
  logic [XFW-1:0]     xf2_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      op2_q    <= op1_q;
      ret2_q   <= ret1_q;
      abr2_q   <= abr1_q;
      large2_q <= x1_q >= XLim;
      b2_q     <= BW'(b_prod >>> F);
      ft2_q    <= ft_prod[K3 +: F+3];
      t2a2_q   <= t2a1_q;
      pq2_q    <= pq1_q;
      y2_q     <= y_prod[30 +: YW];
      xf2_q    <= xf_prod[F +: XFW];
    end
  end

  // ---------------- stage 2 (exp lookup runs alongside) ----------------
  logic signed [SW-1:0]     s_sum;
  logic signed [SW+TW:0]    m_prod;
  logic signed [F+37:0]     dv_prod;
  gfwe_pkg::exp_en_t        exp_en;
  logic [6:0]               n4;
  logic [30:0]              v4;

  assign s_sum   = $signed({4'b0000, t2a2_q}) - $signed({2'b00, ft2_q})
                 + $signed({2'b00, pq2_q, 1'b0});
  assign m_prod  = $signed({1'b0, t2a2_q}) * s_sum;
  assign dv_prod = gain_q * $signed({b2_q, 2'b00});
  assign exp_en.lookup = en[2];
  assign exp_en.interp = en[3];

  gfwe_exp #(
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS),
    .EXP_SEGMENTS    (EXP_SEGMENTS)
  ) u_exp (
    .clk_i (clk_i),
    .en_i  (exp_en),
    .y_i   (y2_q),
    .n_o   (n4),
    .v_o   (v4)
  );

  logic               op3_q, ret3_q, abr3_q, large3_q;
  logic signed [PVW-1:0] dv3_q;
  logic signed [SW-1:0]  m3_q;
  logic [XFW-1:0]     xf3_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      op3_q    <= op2_q;
      ret3_q   <= ret2_q;
      abr3_q   <= abr2_q;
      large3_q <= large2_q;
      dv3_q    <= PVW'(dv_prod >>> F);
      m3_q     <= SW'(m_prod >>> F);
      xf3_q    <= xf2_q;
    end
  end

  // ---------------- stage 3 ----------------
  logic signed [SW+31:0] fv_prod;
  logic signed [PVW-1:0] fv;

  assign fv_prod = gain_q * m3_q;
  assign fv      = PVW'(fv_prod >>> F);

  logic               op4_q, ret4_q, abr4_q, large4_q;
  logic signed [PVW-1:0] poly4_q;
  logic [XFW-1:0]     xf4_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      op4_q    <= op3_q;
      ret4_q   <= ret3_q;
      abr4_q   <= abr3_q;
      large4_q <= large3_q;
      poly4_q  <= op3_q ? fv : dv3_q;
      xf4_q    <= xf3_q;
    end
  end

  // ---------------- stage 4: e, R*(e-E), 1-e-xE ----------------
  logic [30:0]           v_sh;
  logic [TW-1:0]         e4;
  logic signed [F+1:0]   e_diff;
  logic signed [F+33:0]  p_prod;
  logic signed [TMW-1:0] term;

  assign v_sh   = (v4 >> n4) >> (30 - F);
  assign e4     = (large4_q || n4 >= 7'd31) ? '0 : v_sh[TW-1:0];
  assign e_diff = $signed({1'b0, e4}) - $signed({1'b0, fl_q});
  assign p_prod = rscale_q * e_diff;
  assign term   = $signed({{(TMW-TW){1'b0}}, OneT}) - $signed({{(TMW-TW){1'b0}}, e4})
                - $signed({1'b0, xf4_q});

  logic               op5_q, ret5_q, abr5_q;
  logic signed [PVW-1:0] poly5_q;
  logic signed [PPW-1:0] p5_q;
  logic signed [TMW-1:0] term5_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      op5_q   <= op4_q;
      ret5_q  <= ret4_q;
      abr5_q  <= abr4_q;
      poly5_q <= poly4_q;
      p5_q    <= PPW'(p_prod >>> F);
      term5_q <= term;
    end
  end

  // ---------------- stage 5: return-phase products ----------------
  logic signed [PPW+32:0] dr_prod;
  logic signed [TMW+31:0] fr_prod;

  assign dr_prod = p5_q * $signed({1'b0, irt_q});
  assign fr_prod = rscale_q * term5_q;

  logic               op6_q, ret6_q, abr6_q;
  logic signed [PVW-1:0] poly6_q;
  logic signed [VW-1:0]  dr6_q, fr6_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      op6_q   <= op5_q;
      ret6_q  <= ret5_q;
      abr6_q  <= abr5_q;
      poly6_q <= poly5_q;
      dr6_q   <= VW'(dr_prod >>> 16);
      fr6_q   <= VW'(fr_prod >>> F) + VW'(gte_q);
    end
  end

  // ---------------- stage 6: select and saturate ----------------
  logic signed [VW-1:0] val;
  logic [31:0]          sat;

  always_comb begin
    if (!ret6_q) val = VW'(poly6_q);
    else if (abr6_q) val = '0;
    else if (op6_q) val = fr6_q;
    else val = dr6_q;
    if (val > VW'(64'sh7FFF_FFFF)) sat = 32'h7FFF_FFFF;
    else if (val < -VW'(64'sh8000_0000)) sat = 32'h8000_0000;
    else sat = val[31:0];
  end

  logic [31:0] out_q;
  logic        ret7_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      out_q  <= sat;
      ret7_q <= ret6_q;
    end
  end

  assign m_axis_tvalid_o = v_q[NST-1];
  assign m_axis_tdata_o  = out_q;
  assign m_axis_tuser_o  = ret7_q;

`ifndef SYNTHESIS
  // Input only stalls when every stage holds an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (&v_q))
    else $error("input stalled with a free stage");

  // An accepted item lands in the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> v_q[0])
    else $error("accepted item lost at entry");

  // Abrupt closure gives zero beyond Te
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en[6] && v_q[5] && ret6_q && abr6_q |=> m_axis_tdata_o == '0)
    else $error("abrupt closure value not zero");
`endif

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the glottal flow waveform evaluator.
`timescale 1ns / 100ps

module testbench;

  localparam int F = 16;
  localparam int SEGS = 64;
  localparam longint ONE_T = 64'sd1 << F;
  localparam longint X_CEIL = 64'sd64 << F;     // exp returns zero from here on
  localparam int DRAIN_CYCLES = 12;             // pipeline is 7 deep
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [31:0] sample;
    logic        in_return;
  } sample_t;

  // Register image the predictor works from
  typedef struct {
    longint gain, te, tp, tx, inv_ta, ret_scale, e_floor, g_close;
  } glottal_cfg_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i = '0;       // phase[16:0], zero padded
  logic        s_axis_tuser_i = 1'b0;     // operation
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;            // sample_value
  logic        m_axis_tuser_o;            // in_return_phase
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_addr_i = '0;
  logic [31:0] cfg_data_i = '0;

  glottal_flow_waveform_evaluator dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  glottal_cfg_t cfg_now;
  longint       exp_tab [0:SEGS];
  sample_t      expected_samples[$];
  int           mismatch_count = 0;
  int           quiet_cycles = 0;
  bit           steady_flow = 1'b0;   // when set neither side idles

  // ---------------------------------------------------------------- predictor

  // floor(a*b / 2^s), saturated to +-2^62
  function automatic longint fx_mul(longint a, longint b, int s);
    logic signed [127:0] pa, pb, p;
    logic signed [127:0] lim;
    pa = a;
    pb = b;
    lim = 128'sd1 <<< 62;
    p = (pa * pb) >>> s;
    if (p > lim) p = lim;
    if (p < -lim) p = -lim;
    return longint'(p);
  endfunction

  function automatic void fill_exp_table();
    longint z, term, sum;
    for (int k = 0; k <= SEGS; k++) begin
      z = (longint'(k) * gfwe_pkg::LN2_Q30) / SEGS;
      term = gfwe_pkg::ONE_Q30;
      sum = gfwe_pkg::ONE_Q30;
      for (int n = 1; n <= 16; n++) begin
        term = ((term * z) >>> 30) / n;
        sum = (n % 2 == 1) ? sum - term : sum + term;
      end
      if (sum < 0) sum = 0;
      if (sum > gfwe_pkg::ONE_Q30) sum = gfwe_pkg::ONE_Q30;
      exp_tab[k] = sum;
    end
  endfunction

  // exp(-x) for x >= 0 in Q.16, result Q0.30
  function automatic longint decay_q30(longint x);
    longint y, n, pos, k, w, v;
    if (x >= X_CEIL) return 0;
    y = fx_mul(x, longint'(gfwe_pkg::LOG2E_Q30), 30);
    n = y >>> F;
    pos = (y & (ONE_T - 1)) * SEGS;
    k = pos >>> F;
    w = pos & (ONE_T - 1);
    if (k >= SEGS) begin
      k = SEGS - 1;
      w = ONE_T - 1;
    end
    v = exp_tab[k] - (((exp_tab[k] - exp_tab[k + 1]) * w) >>> F);
    return (n < 31) ? (v >>> n) : 0;
  endfunction

  function automatic sample_t glottal_sample(logic [16:0] phase, logic op_flow);
    sample_t r;
    longint t, val, a, b, t2, ts, ft, pq, m, x, e, p, term;
    t = phase;
    if (t > ONE_T) t = ONE_T;
    r.in_return = (t > cfg_now.te);
    if (!r.in_return) begin
      if (!op_flow) begin
        a = fx_mul(t, cfg_now.tp - t, F);
        b = fx_mul(a, cfg_now.tx - t, F);
        val = fx_mul(cfg_now.gain, 4 * b, F);
      end else begin
        t2 = fx_mul(t, t, F);
        ts = fx_mul(t, cfg_now.tp + cfg_now.tx, F);
        ft = (4 * ts) / 3;
        pq = fx_mul(cfg_now.tp, cfg_now.tx, F);
        m = fx_mul(t2, t2 - ft + 2 * pq, F);
        val = fx_mul(cfg_now.gain, m, F);
      end
    end else if (cfg_now.inv_ta == 0) begin
      val = 0;                                   // abrupt closure
    end else begin
      x = fx_mul(t - cfg_now.te, cfg_now.inv_ta, 16);
      e = decay_q30(x) >>> (30 - F);
      if (!op_flow) begin
        p = fx_mul(cfg_now.ret_scale, e - cfg_now.e_floor, F);
        val = fx_mul(p, cfg_now.inv_ta, 16);
      end else begin
        term = ONE_T - e - fx_mul(x, cfg_now.e_floor, F);
        val = cfg_now.g_close + fx_mul(cfg_now.ret_scale, term, F);
      end
    end
    if (val > 64'sd2147483647) val = 64'sd2147483647;
    if (val < -64'sd2147483648) val = -64'sd2147483648;
    r.sample = val[31:0];
    return r;
  endfunction

  // ------------------------------------------------------- input side monitor

  always @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o)
      expected_samples.push_back(glottal_sample(s_axis_tdata_i[16:0], s_axis_tuser_i));
  end

  // ------------------------------------------------------ output side checker

  task automatic report_mismatch(string what);
    $display("mismatch @%0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  int out_hold = 0;
  always @(posedge clk_i) begin
    sample_t want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_samples.size() == 0) begin
        report_mismatch("result item with nothing expected");
      end else begin
        want = expected_samples.pop_front();
        if (m_axis_tdata_o !== want.sample)
          report_mismatch($sformatf("sample_value got %h want %h",
                                    m_axis_tdata_o, want.sample));
        if (m_axis_tuser_o !== want.in_return)
          report_mismatch($sformatf("in_return_phase got %b want %b",
                                    m_axis_tuser_o, want.in_return));
      end
      out_hold = steady_flow ? 0 : $urandom_range(0, 4);
    end
    // receiver stalls a random number of cycles after each item
    if (out_hold > 0) begin
      out_hold--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // ------------------------------------------------------------------ watchdog

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ------------------------------------------------------------ driver tasks

  task automatic send_phase(logic [16:0] phase, logic op_flow);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {7'd0, phase};
    s_axis_tuser_i <= op_flow;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // Waits until every expected result is back and the pipeline is empty
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Leaves cfg_valid_i high; the caller drops it after its last write
  task automatic write_reg(gfwe_pkg::cfg_reg_e idx, logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      gfwe_pkg::REG_GAIN_K:     cfg_now.gain = longint'($signed(value));
      gfwe_pkg::REG_OPEN_END:   cfg_now.te = value[16:0];
      gfwe_pkg::REG_PEAK_TIME:  cfg_now.tp = value[16:0];
      gfwe_pkg::REG_SHAPE_TIME: cfg_now.tx = value[16:0];
      gfwe_pkg::REG_INV_RET:    cfg_now.inv_ta = value;
      gfwe_pkg::REG_RET_SCALE:  cfg_now.ret_scale = longint'($signed(value));
      gfwe_pkg::REG_EXP_FLOOR:  cfg_now.e_floor = value[16:0];
      gfwe_pkg::REG_FLOW_CLOSE: cfg_now.g_close = longint'($signed(value));
      default: ;
    endcase
  endtask

  task automatic load_all(logic [31:0] k, logic [31:0] te, logic [31:0] tp, logic [31:0] tx,
                          logic [31:0] inv, logic [31:0] rs, logic [31:0] ef,
                          logic [31:0] gc);
    wait_drained();
    write_reg(gfwe_pkg::REG_GAIN_K, k);
    write_reg(gfwe_pkg::REG_OPEN_END, te);
    write_reg(gfwe_pkg::REG_PEAK_TIME, tp);
    write_reg(gfwe_pkg::REG_SHAPE_TIME, tx);
    write_reg(gfwe_pkg::REG_INV_RET, inv);
    write_reg(gfwe_pkg::REG_RET_SCALE, rs);
    write_reg(gfwe_pkg::REG_EXP_FLOOR, ef);
    write_reg(gfwe_pkg::REG_FLOW_CLOSE, gc);
    cfg_valid_i <= 1'b0;
  endtask

  // ----------------------------------------------------------------- tests

  // Reset values: gain 0 gives zero open phase, return phase is abrupt
  task automatic test_reset_defaults();
    send_phase(17'd0, 1'b0);
    send_phase(17'd39322, 1'b1);
    send_phase(17'd39323, 1'b0);
    send_phase(17'd65536, 1'b1);
  endtask

  // Open phase polynomials, phases over one clamp, abrupt closure
  task automatic test_open_phase();
    load_all(32'h0001_8000, 32'd39322, 32'd27525, 32'd45875, 32'd0,
             32'h0002_0000, 32'd3000, 32'h0000_4000);
    for (int op = 0; op < 2; op++) begin
      send_phase(17'd0, op[0]);
      send_phase(17'd20000, op[0]);
      send_phase(17'd39322, op[0]);
      send_phase(17'd39323, op[0]);          // first abrupt-closure phase
      send_phase(17'd65536, op[0]);
      send_phase(17'h1FFFF, op[0]);          // above one, clamped
    end
  endtask

  // Exponential return: gentle decay, then a huge exponent that zeroes e
  task automatic test_return_phase();
    load_all(32'h0003_0000, 32'd30000, 32'd20000, 32'd40000, 32'h0004_0000,
             32'hFFFE_8000, 32'd1200, 32'hFFFF_0123);
    for (int op = 0; op < 2; op++) begin
      send_phase(17'd30001, op[0]);
      send_phase(17'd45000, op[0]);
      send_phase(17'd65536, op[0]);
    end
    wait_drained();
    write_reg(gfwe_pkg::REG_INV_RET, 32'hFFFF_FFFF);
    cfg_valid_i <= 1'b0;
    send_phase(17'd30001, 1'b0);
    send_phase(17'd65535, 1'b1);
  endtask

  // Register extremes, including times above one used as given
  task automatic test_extremes();
    load_all(32'h7FFF_FFFF, 32'h0001_FFFF, 32'h0001_FFFF, 32'd0, 32'd0,
             32'h7FFF_FFFF, 32'h0001_FFFF, 32'h7FFF_FFFF);
    send_phase(17'd65536, 1'b0);
    send_phase(17'd32768, 1'b1);
    load_all(32'h8000_0000, 32'd0, 32'd0, 32'h0001_0000, 32'hFFFF_FFFF,
             32'h8000_0000, 32'd0, 32'h8000_0000);
    send_phase(17'd0, 1'b1);
    send_phase(17'd1, 1'b0);
    send_phase(17'h1FFFF, 1'b1);
  endtask

  function automatic logic [31:0] rand_time();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'd65536;
      2: return $urandom;                    // upper bits get masked off
      default: return $urandom_range(0, 65536);
    endcase
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom;
      default: return $signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000;
    endcase
  endfunction

  function automatic logic [31:0] rand_inv();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return $urandom;
      default: return $urandom_range(32'h0000_4000, 32'h0040_0000);
    endcase
  endfunction

  task automatic test_random();
    logic [16:0] ph;
    for (int setting = 0; setting < 12; setting++) begin
      load_all(rand_word(), rand_time(), rand_time(), rand_time(), rand_inv(),
               rand_word(), rand_time(), rand_word());
      steady_flow = (setting % 4 == 3);
      for (int i = 0; i < 140; i++) begin
        if (i == 70 && setting == 5) begin
          // hold off until every result of this setting is back
          s_axis_tvalid_i <= 1'b0;
          @(posedge clk_i);
          while (expected_samples.size() != 0) @(posedge clk_i);
        end
        case ($urandom_range(0, 9))
          0: ph = $urandom;                          // any 17-bit pattern
          1: ph = cfg_now.te[16:0] + 17'($urandom_range(0, 2)) - 17'd1;
          default: ph = $urandom_range(0, 65536);
        endcase
        send_phase(ph, 1'($urandom_range(0, 1)));
      end
      steady_flow = 1'b0;
    end
  endtask

  initial begin
    fill_exp_table();
    cfg_now = '{gain: 0, te: 39322, tp: 27525, tx: 45875, inv_ta: 0,
                ret_scale: 0, e_floor: 0, g_close: 0};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_open_phase();
    test_return_phase();
    test_extremes();
    test_random();

    wait_drained();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
